[design/ouis_pkg.sv]
// shared types and constants for the ordered unique id set
// no dependencies
`default_nettype none

package ouis_pkg;

  localparam int MaxEntries = 64;
  localparam int IdW        = 32;
  localparam int OutCntW    = 7;
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam int IdxW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;

  typedef enum logic [1:0] {
    ModeContains = 2'd0,
    ModeAdd      = 2'd1,
    ModeRemove   = 2'd2,
    ModeClear    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StMiss    = 2'd1,
    StFull    = 2'd2,
    StInvalid = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SRead,
    SCmp,
    SShRd,
    SShWr,
    SDone
  } state_e;

  typedef struct packed {
    mode_e           mode;
    logic [IdW-1:0]  window_id;
  } in_t;

  typedef struct packed {
    status_e              status;
    logic [OutCntW-1:0]   entry_count;
  } out_t;

endpackage

`default_nettype wire

[design/ouis_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module ouis_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/ouis_ctrl.sv]
// sequencer: linear search, append and shift-down compaction over the id ram
// depends on ouis_pkg
`default_nettype none

module ouis_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire ouis_pkg::in_t           in_word_i,
  output logic                         res_valid_o,
  input  wire logic                    res_ready_i,
  output ouis_pkg::out_t               res_o,
  output logic                         ram_we_o,
  output logic [ouis_pkg::IdxW-1:0]    ram_waddr_o,
  output logic [ouis_pkg::IdW-1:0]     ram_wdata_o,
  output logic                         ram_re_o,
  output logic [ouis_pkg::IdxW-1:0]    ram_raddr_o,
  input  wire logic [ouis_pkg::IdW-1:0] ram_rdata_i
);

  ouis_pkg::state_e               state_q, state_d;
  logic [ouis_pkg::CntW-1:0]      count_q, count_d;
  logic [ouis_pkg::CntW-1:0]      idx_q, idx_d;
  ouis_pkg::status_e              status_q, status_d;
  ouis_pkg::mode_e                mode_q, mode_d;
  logic [ouis_pkg::IdW-1:0]       id_q, id_d;
  logic                           found;
  logic                           hit;
  logic [ouis_pkg::CntW-1:0]      idx_dec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ouis_pkg::SIdle;
      count_q  <= '0;
      idx_q    <= '0;
      status_q <= ouis_pkg::StOk;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    id_q   <= id_d;
  end

  assign idx_dec = idx_q - ouis_pkg::CntW'(1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    status_d    = status_q;
    mode_d      = mode_q;
    id_d        = id_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = count_q[ouis_pkg::IdxW-1:0];
    ram_wdata_o = id_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = idx_q[ouis_pkg::IdxW-1:0];
    found       = 1'b0;
    hit         = 1'b0;

    case (state_q)
      ouis_pkg::SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mode_d = in_word_i.mode;
          id_d   = in_word_i.window_id;
          idx_d  = '0;
          if (in_word_i.mode == ouis_pkg::ModeClear) begin
            count_d  = '0;
            status_d = ouis_pkg::StOk;
            state_d  = ouis_pkg::SDone;
          end else if (in_word_i.window_id == '0) begin
            status_d = ouis_pkg::StInvalid;
            state_d  = ouis_pkg::SDone;
          end else begin
            state_d = ouis_pkg::SRead;
          end
        end
      end
      ouis_pkg::SRead: begin
        if (idx_q >= count_q) begin
          hit = 1'b1;
        end else begin
          ram_re_o = 1'b1;
          state_d  = ouis_pkg::SCmp;
        end
      end
      ouis_pkg::SCmp: begin
        if (ram_rdata_i == id_q) begin
          hit   = 1'b1;
          found = 1'b1;
        end else begin
          idx_d   = idx_q + ouis_pkg::CntW'(1);
          state_d = ouis_pkg::SRead;
        end
      end
      ouis_pkg::SShRd: begin
        if (idx_q >= count_q) begin
          count_d = count_q - ouis_pkg::CntW'(1);
          state_d = ouis_pkg::SDone;
        end else begin
          ram_re_o = 1'b1;
          state_d  = ouis_pkg::SShWr;
        end
      end
      ouis_pkg::SShWr: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = idx_dec[ouis_pkg::IdxW-1:0];
        ram_wdata_o = ram_rdata_i;
        idx_d       = idx_q + ouis_pkg::CntW'(1);
        state_d     = ouis_pkg::SShRd;
      end
      ouis_pkg::SDone: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ouis_pkg::SIdle;
        end
      end
      default: begin
        state_d = ouis_pkg::SIdle;
      end
    endcase

    // search finished: act on the mode
    if (hit) begin
      state_d = ouis_pkg::SDone;
      case (mode_q)
        ouis_pkg::ModeContains: begin
          status_d = found ? ouis_pkg::StOk : ouis_pkg::StMiss;
        end
        ouis_pkg::ModeAdd: begin
          if (found) begin
            status_d = ouis_pkg::StMiss;
          end else if (32'(count_q) >= ouis_pkg::MaxEntries) begin
            status_d = ouis_pkg::StFull;
          end else begin
            status_d = ouis_pkg::StOk;
            ram_we_o = 1'b1;
            count_d  = count_q + ouis_pkg::CntW'(1);
          end
        end
        ouis_pkg::ModeRemove: begin
          if (found) begin
            status_d = ouis_pkg::StOk;
            idx_d    = idx_q + ouis_pkg::CntW'(1);
            state_d  = ouis_pkg::SShRd;
          end else begin
            status_d = ouis_pkg::StMiss;
          end
        end
        default: begin
          status_d = ouis_pkg::StOk;
        end
      endcase
    end
  end

  assign res_o.status      = status_q;
  assign res_o.entry_count = ouis_pkg::OutCntW'(32'(count_q));

endmodule

`default_nettype wire

[design/ordered_unique_id_set_top.sv]
// top level of the ordered unique id set: sequencer, id ram and output register
// depends on ouis_pkg, ouis_ram, ouis_ctrl
`default_nettype none

// Keeps an insertion-ordered list of up to 64 unique nonzero 32-bit ids in a
// single-port-read ram. One request word is taken at a time; in_ready_o is low
// while the sequencer walks the ram. Each ram entry is visited by a read, then
// a compare or a move. A contains or add compares entries until the id is found
// or all stored ids are checked; a remove searches the same way and then moves
// every later entry down by one; clear or an invalid id skip the walk. The
// result word sits in an output register, so the next request is taken while
// it waits.
module ordered_unique_id_set_top (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire ouis_pkg::in_t  in_word_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output ouis_pkg::out_t      out_word_o
);

  logic                        res_valid;
  logic                        res_ready;
  ouis_pkg::out_t              res;
  logic                        ram_we;
  logic [ouis_pkg::IdxW-1:0]   ram_waddr;
  logic [ouis_pkg::IdW-1:0]    ram_wdata;
  logic                        ram_re;
  logic [ouis_pkg::IdxW-1:0]   ram_raddr;
  logic [ouis_pkg::IdW-1:0]    ram_rdata;
  logic                        out_valid_q, out_valid_d;
  ouis_pkg::out_t              out_word_q;

  ouis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  ouis_ram #(
    .Width (ouis_pkg::IdW),
    .Depth (ouis_pkg::MaxEntries),
    .AddrW (ouis_pkg::IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire
